// ===== hdl/mssc_pkg.sv =====
// ---------------------------------------------------------------------------
// mssc_pkg
// shared constants and types for the minimum square sum counter
// ---------------------------------------------------------------------------
`default_nettype none

package mssc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int TARGET_W    = 12;
    localparam int COUNT_W     = 3;

    // one access to the count table, read or write
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [COUNT_W-1:0] wdata;
    } mssc_ram_req_t;

endpackage

`default_nettype wire

// ===== hdl/mssc_table.sv =====
// ---------------------------------------------------------------------------
// mssc_table
// single-port count table, registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module mssc_table
    import mssc_pkg::*;
(
    input  wire logic                clk,
    input  wire mssc_ram_req_t       req,
    output logic [COUNT_W-1:0]       rd_data
);

    logic [COUNT_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mssc_seq.sv =====
// ---------------------------------------------------------------------------
// mssc_seq
// sequencer that fills the count table bottom-up and reports the answer;
// targets of 3 or less are answered without the table
`default_nettype none

module mssc_seq
    import mssc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [TARGET_W-1:0] target,
    output logic                     idle,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output logic [COUNT_W-1:0]       result,
    output mssc_ram_req_t            ram_req,
    input  wire logic [COUNT_W-1:0]  rd_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  n_reg, n_next;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic [ADDR_W:0]    sq_reg, sq_next;
    logic [ADDR_W:0]    odd_reg, odd_next;
    logic [COUNT_W-1:0] best_reg, best_next;
    logic               pend_reg, pend_next;

    logic [ADDR_W-1:0]  n_in;
    logic [COUNT_W:0]   cand;
    logic [COUNT_W-1:0] best_eff;
    logic [ADDR_W-1:0]  i_inc;

    // clamp a target beyond the table to its last entry
    always_comb
    begin
        if (int'(target) >= TABLE_DEPTH)
        begin
            n_in = ADDR_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            n_in = ADDR_W'(target);
        end
    end

    assign cand  = {1'b0, rd_data} + (COUNT_W+1)'(1);
    assign i_inc = i_reg + ADDR_W'(1);

    // fold in the entry read last cycle
    always_comb
    begin
        best_eff = best_reg;
        if (pend_reg && (cand < {1'b0, best_reg}))
        begin
            best_eff = cand[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        sq_next      = sq_reg;
        odd_next     = odd_reg;
        best_next    = best_reg;
        pend_next    = 1'b0;
        ram_req      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next = n_in;
                    i_next = '0;
                    if (n_in <= ADDR_W'(3))
                    begin
                        best_next  = COUNT_W'(n_in);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_BASE;
                    end
                end
            end
            S_BASE:
            begin
                // entries 0 to 3 hold their own index
                ram_req.we    = 1'b1;
                ram_req.addr  = i_reg;
                ram_req.wdata = COUNT_W'(i_reg);
                if (i_reg == ADDR_W'(3))
                begin
                    i_next     = ADDR_W'(4);
                    sq_next    = (ADDR_W+1)'(1);
                    odd_next   = (ADDR_W+1)'(3);
                    best_next  = COUNT_W'(4);
                    state_next = S_READ;
                end
                else
                begin
                    i_next = i_inc;
                end
            end
            S_READ:
            begin
                ram_req.re   = 1'b1;
                ram_req.addr = i_reg - sq_reg[ADDR_W-1:0];
                pend_next    = 1'b1;
                best_next    = best_eff;
                if ((sq_reg + odd_reg) > {1'b0, i_reg})
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    sq_next  = sq_reg + odd_reg;
                    odd_next = odd_reg + (ADDR_W+1)'(2);
                end
            end
            S_WRITE:
            begin
                // last read lands here, entry i is final
                ram_req.we    = 1'b1;
                ram_req.addr  = i_reg;
                ram_req.wdata = best_eff;
                if (i_reg == n_reg)
                begin
                    best_next  = best_eff;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next   = i_inc;
                    sq_next  = (ADDR_W+1)'(1);
                    odd_next = (ADDR_W+1)'(3);
                    if (i_inc < ADDR_W'(7))
                    begin
                        best_next = COUNT_W'(i_inc);
                    end
                    else
                    begin
                        best_next = COUNT_W'(7);
                    end
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (result_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle         = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_DONE);
    assign result       = best_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        i_reg    <= i_next;
        sq_reg   <= sq_next;
        odd_reg  <= odd_next;
        best_reg <= best_next;
    end

endmodule

`default_nettype wire

// ===== hdl/min_square_sum_count.sv =====
// ---------------------------------------------------------------------------
// min_square_sum_count
// fewest perfect squares that sum to a number
// ---------------------------------------------------------------------------
// usage:
//   an item on the target channel (target_valid/target_ready, target) asks
//   for the fewest perfect squares summing to target; one item comes back
//   on the count channel (count_valid/count_ready, square_count).
//   one item is worked on at a time; target_ready is high only while the
//   sequencer is idle.
// operation:
//   a target of 3 or less is answered without the table. a larger target
//   n writes table entries 0 to 3, then for each i from 4 to n issues one
//   table read per square not above i plus one write; the single table
//   port takes these accesses one after another.
// reset: rst_n clears the sequencer and the output valid; the table needs
//   no clearing, every entry is written before it is read.
// stalls: the answer sits in the output register until count_ready; a new
//   target is taken meanwhile, and a finished answer waits in the sequencer
//   until the output register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module min_square_sum_count
    import mssc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                target_valid,
    output logic                     target_ready,
    input  wire logic [TARGET_W-1:0] target,
    output logic                     count_valid,
    input  wire logic                count_ready,
    output logic [COUNT_W-1:0]       square_count
);

    mssc_ram_req_t       ram_req;
    logic [COUNT_W-1:0]  rd_data;
    logic                idle;
    logic                res_valid;
    logic                res_ready;
    logic [COUNT_W-1:0]  res;
    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  out_data_reg;

    assign target_ready = idle;
    assign res_ready    = !out_valid_reg || count_ready;

    mssc_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (target_valid),
        .target       (target),
        .idle         (idle),
        .result_valid (res_valid),
        .result_ready (res_ready),
        .result       (res),
        .ram_req      (ram_req),
        .rd_data      (rd_data)
    );

    mssc_table u_table (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (count_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign count_valid  = out_valid_reg;
    assign square_count = out_data_reg;

endmodule

`default_nettype wire
